// ===== design/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP matcher.
package kmp_pkg;

	localparam int PATTERN_MAX_DEF   = 256;
	localparam int TEXT_POS_BITS_DEF = 20;
	localparam int START_W           = 20;
	localparam int BYTE_W            = 8;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	typedef struct packed {
		logic              op;
		logic              first;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic               match;
		logic [START_W-1:0] match_start;
		logic               found_any;
		logic               pattern_full;
	} result_t;

	// Per-beat commands broadcast to every cell of the row.
	typedef struct packed {
		logic append;
		logic scan;
		logic clear_pat;
		logic clear_text;
	} cell_ctl_t;

endpackage

// ===== design/kmp_cell.sv =====
// One matcher cell: holds one pattern byte, its occupancy and its prefix-match bit.
module kmp_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kmp_pkg::cell_ctl_t        ctl,
	input  logic [kmp_pkg::BYTE_W-1:0] data_byte,
	input  logic                      prev_occ_kept,
	input  logic                      prev_hit,
	input  logic                      next_occ,
	output logic                      occ,
	output logic                      occ_kept,
	output logic                      hit,
	output logic                      full_hit
);
	import kmp_pkg::*;

	logic              occ_q;
	logic              hit_q;
	logic [BYTE_W-1:0] pat_q;
	logic              write_here;
	logic              is_last;
	logic              hit_d;

	assign occ        = occ_q;
	assign occ_kept   = occ_q & ~ctl.clear_pat;
	// first free slot behind an occupied one takes the appended byte
	assign write_here = ctl.append & prev_occ_kept & ~occ_kept;
	assign is_last    = occ_q & ~next_occ;
	assign hit_d      = prev_hit & occ_q & (pat_q == data_byte);
	assign full_hit   = ctl.scan & hit_d & is_last;
	// a new text drops all partial matches held for the neighbor
	assign hit        = hit_q & ~ctl.clear_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (ctl.clear_pat || write_here) begin
			occ_q <= write_here;
			hit_q <= 1'b0;
		end else if (ctl.scan) begin
			// drop the full-length match, keep only proper prefixes
			hit_q <= hit_d & ~is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (write_here) begin
			pat_q <= data_byte;
		end
	end

endmodule

// ===== design/kmp_stream_matcher.sv =====
// Streaming KMP matcher built as a row of pattern cells with a registered result.
// The result of an accepted beat is registered and valid in the next cycle.
// Throughput: one beat per cycle unless the result stalls; every cell compares and shifts
// its prefix bit per beat. The result register takes a new beat if empty or being drained.
// Reset clears the pattern, text position, match bits and found flag; no clearing pass.
module kmp_stream_matcher #(
	parameter int PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
	parameter int TEXT_POS_BITS = kmp_pkg::TEXT_POS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  kmp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output kmp_pkg::result_t result
);
	import kmp_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int SUB_W = ((TEXT_POS_BITS > LEN_W) ? TEXT_POS_BITS : LEN_W) + 1;
	localparam int EXT_W = (TEXT_POS_BITS > START_W) ? TEXT_POS_BITS : START_W;
	localparam logic [TEXT_POS_BITS-1:0] POS_MAX = {TEXT_POS_BITS{1'b1}};

	logic                     step;
	cell_ctl_t                ctl;
	logic [PATTERN_MAX-1:0]   occ_vec;
	logic [PATTERN_MAX-1:0]   occ_kept_vec;
	logic [PATTERN_MAX-1:0]   hit_vec;
	logic [PATTERN_MAX-1:0]   full_vec;

	logic [LEN_W-1:0]         len_q;
	logic [TEXT_POS_BITS-1:0] pos_q;
	logic                     found_q;
	logic                     result_valid_q;
	result_t                  result_q;

	logic                     store_full;
	logic                     match;
	logic                     found_d;
	logic [TEXT_POS_BITS-1:0] pos_eff;
	logic [SUB_W-1:0]         start_diff;
	logic [EXT_W-1:0]         start_ext;

	assign item_ready   = ~result_valid_q | result_ready;
	assign step         = item_valid & item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ctl.append     = step & (item.op == OP_PATTERN);
	assign ctl.scan       = step & (item.op == OP_TEXT);
	assign ctl.clear_pat  = step & (item.op == OP_PATTERN) & item.first;
	assign ctl.clear_text = step & item.first;

	genvar gi;
	generate
		for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
			logic prev_occ_kept;
			logic prev_hit;
			logic next_occ;
			if (gi == 0) begin : g_head
				assign prev_occ_kept = 1'b1;
				assign prev_hit      = 1'b1;
			end else begin : g_body
				assign prev_occ_kept = occ_kept_vec[gi-1];
				assign prev_hit      = hit_vec[gi-1];
			end
			if (gi == PATTERN_MAX - 1) begin : g_tail
				assign next_occ = 1'b0;
			end else begin : g_mid
				assign next_occ = occ_vec[gi+1];
			end
			kmp_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl),
				.data_byte    (item.data_byte),
				.prev_occ_kept(prev_occ_kept),
				.prev_hit     (prev_hit),
				.next_occ     (next_occ),
				.occ          (occ_vec[gi]),
				.occ_kept     (occ_kept_vec[gi]),
				.hit          (hit_vec[gi]),
				.full_hit     (full_vec[gi])
			);
		end
	endgenerate

	assign store_full = occ_kept_vec[PATTERN_MAX-1];
	assign match      = |full_vec;
	assign found_d    = (found_q & ~item.first) | match;
	assign pos_eff    = item.first ? '0 : pos_q;
	assign start_diff = SUB_W'(pos_eff) + SUB_W'(1) - SUB_W'(len_q);
	assign start_ext  = EXT_W'(start_diff[TEXT_POS_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= '0;
			pos_q          <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (step) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (ctl.clear_pat) begin
				len_q <= LEN_W'(1);
			end else if (ctl.append && !store_full) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (ctl.scan) begin
				// hold the position once it saturates
				pos_q <= (pos_eff == POS_MAX) ? pos_eff : pos_eff + TEXT_POS_BITS'(1);
			end else if (ctl.clear_text) begin
				pos_q <= '0;
			end
			if (step) begin
				found_q <= found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q.match        <= match;
			result_q.match_start  <= match ? start_ext[START_W-1:0] : '0;
			result_q.found_any    <= found_d;
			result_q.pattern_full <= ctl.append & store_full;
		end
	end

endmodule

// ===== design/kmp_checker.sv =====
// Port-level checks for the streaming KMP matcher, bound to the top level.
module kmp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input kmp_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input kmp_pkg::result_t result
);
	import kmp_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_beat_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted beat produced no result");

	a_match_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.match |-> result.found_any)
		else $error("match reported without found flag");

	a_full_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pattern_full |-> !result.match && result.match_start == '0)
		else $error("pattern beat reported a match");

	a_pattern_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.op == OP_PATTERN |=> !result.match)
		else $error("pattern beat reported a match");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (.*);
